@@ design/pll_divider_search_defines.svh @@
// Assertion macros shared by the PLL divider search design.
`ifndef PLL_DIVIDER_SEARCH_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define PDS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pll divider search check failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define PDS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pll divider search check failed");

`endif

@@ design/pds_pkg.sv @@
// Types and constants of the PLL divider search.
`default_nettype none

package pds_pkg;

  localparam int unsigned SrcW   = 26;
  localparam int unsigned TgtW   = 27;
  localparam int unsigned ClkW   = 24;
  localparam int unsigned Q6W    = 22;
  localparam int unsigned VcoW   = 31;
  localparam int unsigned FreqW  = 28;
  localparam int unsigned NW     = 7;
  localparam int unsigned MCodeW = 3;
  localparam int unsigned RCodeW = 2;
  localparam int unsigned DivW   = 4;
  localparam int unsigned RemW   = 3;
  localparam int unsigned CntW   = 5;
  localparam int unsigned RecipW = 25;
  localparam int unsigned RecipShift = 27;
  localparam int unsigned ProdW  = ClkW + RecipW;

  localparam logic [TgtW-1:0]   TargetReset = TgtW'(80000000);
  localparam logic [SrcW-1:0]   ClkMin      = SrcW'(4000000);
  localparam logic [SrcW-1:0]   ClkMax      = SrcW'(16000000);
  localparam logic [VcoW-1:0]   VcoMin      = VcoW'(64000000);
  localparam logic [VcoW-1:0]   VcoMax      = VcoW'(344000000);
  localparam logic [NW-1:0]     NLow        = NW'(8);
  localparam logic [NW-1:0]     NHigh       = NW'(86);
  localparam logic [MCodeW-1:0] MCodeLast   = MCodeW'(7);
  localparam logic [MCodeW-1:0] MCodeNone   = MCodeW'(1);
  localparam logic [DivW-1:0]   DivBySix    = DivW'(6);
  localparam logic [CntW-1:0]   DivLastStep = CntW'(SrcW - 1);

  // Reciprocal of six, rounded up, scaled by 2^27; exact for dividends below 2^25.
  localparam logic [RecipW-1:0] RecipSix    = RecipW'(22369622);

  // Output divider codes, r / 2 - 1.
  localparam logic [RCodeW-1:0] RCodeDiv2 = 2'd0;
  localparam logic [RCodeW-1:0] RCodeDiv4 = 2'd1;
  localparam logic [RCodeW-1:0] RCodeDiv6 = 2'd2;
  localparam logic [RCodeW-1:0] RCodeDiv8 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MDIV_GO,
    ST_MDIV_WAIT,
    ST_QDIV_GO,
    ST_QDIV_WAIT,
    ST_SWEEP,
    ST_NEXT_M,
    ST_DONE
  } pds_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_src;
    logic div_go_m;
    logic div_go_6;
    logic cap_clk;
    logic cap_q6;
    logic init_sweep;
    logic sweep_step;
    logic next_m;
    logic load_out;
  } pds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic clk_ok;
    logic n_last;
    logic m_last;
    logic out_busy;
  } pds_stat_t;

endpackage

`default_nettype wire

@@ design/pll_divider_search.sv @@
// Each m runs a serial src/m, one quotient bit per cycle, and a step to the next m;
// an m with src/m in range adds clk/6 and an 87-step VCO sweep.
// Items are taken one at a time: the next input is taken only after the result enters
// the result register, which waits while the previous result drains from the output.
// Reset clears control state and sets the target to 80 MHz; no memory, no clearing pass.
`default_nettype none
`include "pll_divider_search_defines.svh"

module pll_divider_search (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel: target frequency in Hz.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [26:0] cfg_data_i,    // [26:0] target_freq
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [25:0] src_freq, [31:26] zero
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // [2:0] m_code, [9:3] n_mult, [11:10] r_code,
                                          // [38:12] freq_shortfall, [39] zero
);
  import pds_pkg::*;

  logic [TgtW-1:0]   target_q;
  pds_cmd_t          ctrl_cmd;
  pds_stat_t         dp_stat;
  logic [MCodeW-1:0] out_m_code;
  logic [NW-1:0]     out_n_mult;
  logic [RCodeW-1:0] out_r_code;
  logic [TgtW-1:0]   out_shortfall;

  // Target register, written by the configuration channel.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  pds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  pds_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat),
    .src_i           (s_axis_tdata[SrcW-1:0]),
    .target_i        (target_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_m_code_o    (out_m_code),
    .out_n_mult_o    (out_n_mult),
    .out_r_code_o    (out_r_code),
    .out_shortfall_o (out_shortfall)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {1'b0, out_shortfall, out_r_code, out_n_mult, out_m_code};

  // The search starts on every accepted transaction, so the block is busy next cycle.
  `PDS_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A new result only appears after the controller loads the result register.
  `PDS_ASSERT_IMP(a_result_from_load, $rose(m_axis_tvalid), $past(ctrl_cmd.load_out))
  // The chosen multiplier always lies in the legal range.
  `PDS_ASSERT_IMP(a_n_range, m_axis_tvalid, (out_n_mult >= NLow) && (out_n_mult <= NHigh))
  // Sweep steps never coincide with a divider done flag.
  `PDS_ASSERT_IMP(a_sweep_quiet, ctrl_cmd.sweep_step, !dp_stat.div_done)

endmodule

`default_nettype wire

@@ design/pds_div.sv @@
// Restoring divider by a small divisor, one quotient bit per cycle.
`default_nettype none

module pds_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [pds_pkg::SrcW-1:0]  dividend_i,
  input  wire logic [pds_pkg::DivW-1:0]  divisor_i,
  output logic                           done_o,
  output logic [pds_pkg::SrcW-1:0]       quot_o
);
  import pds_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SrcW-1:0]   work_q, work_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [DivW-1:0]   dvs_q, dvs_d;
  logic [DivW-1:0]   trial;
  logic              fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_q, work_q[SrcW-1]};
  assign fits  = trial >= dvs_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      work_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? RemW'(trial - dvs_q) : RemW'(trial);
      work_d = {work_q[SrcW-2:0], fits};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == DivLastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = work_q;

endmodule

`default_nettype wire

@@ design/pds_ctrl.sv @@
// Sequencing state machine of the PLL divider search.
`default_nettype none

module pds_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pds_pkg::pds_stat_t stat_i,
  output pds_pkg::pds_cmd_t       cmd_o
);
  import pds_pkg::*;

  pds_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_MDIV_GO;
      ST_MDIV_GO:   state_d = ST_MDIV_WAIT;
      ST_MDIV_WAIT: begin
        if (stat_i.div_done) state_d = stat_i.clk_ok ? ST_QDIV_GO : ST_NEXT_M;
      end
      ST_QDIV_GO:   state_d = ST_QDIV_WAIT;
      ST_QDIV_WAIT: if (stat_i.div_done) state_d = ST_SWEEP;
      ST_SWEEP:     if (stat_i.n_last) state_d = ST_NEXT_M;
      ST_NEXT_M:    state_d = stat_i.m_last ? ST_DONE : ST_MDIV_GO;
      ST_DONE:      if (!stat_i.out_busy) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_src = in_valid_i;
      end
      ST_MDIV_GO:   cmd_o.div_go_m = 1'b1;
      ST_MDIV_WAIT: cmd_o.cap_clk  = stat_i.div_done;
      ST_QDIV_GO:   cmd_o.div_go_6 = 1'b1;
      ST_QDIV_WAIT: begin
        cmd_o.cap_q6     = stat_i.div_done;
        cmd_o.init_sweep = stat_i.div_done;
      end
      ST_SWEEP:     cmd_o.sweep_step = 1'b1;
      ST_NEXT_M:    cmd_o.next_m     = !stat_i.m_last;
      ST_DONE:      cmd_o.load_out   = !stat_i.out_busy;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/pds_datapath.sv @@
// Datapath: divider, VCO sweep, best-candidate tracking and result register.
`default_nettype none

module pds_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pds_pkg::pds_cmd_t          cmd_i,
  output pds_pkg::pds_stat_t              stat_o,
  input  wire logic [pds_pkg::SrcW-1:0]   src_i,
  input  wire logic [pds_pkg::TgtW-1:0]   target_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [pds_pkg::MCodeW-1:0]      out_m_code_o,
  output logic [pds_pkg::NW-1:0]          out_n_mult_o,
  output logic [pds_pkg::RCodeW-1:0]      out_r_code_o,
  output logic [pds_pkg::TgtW-1:0]        out_shortfall_o
);
  import pds_pkg::*;

  // Search registers.
  logic [SrcW-1:0]   src_q;
  logic [MCodeW-1:0] mcode_q;
  logic [ClkW-1:0]   clk_q;
  logic [Q6W-1:0]    q6_q;
  logic [RemW-1:0]   r6_q;
  logic              q6_done_q;
  logic [NW-1:0]     n_q;
  logic [VcoW-1:0]   vco_q;
  logic [FreqW-1:0]  f6_q;
  logic [RemW-1:0]   rem6_q;
  logic [TgtW-1:0]   best_diff_q;
  logic [MCodeW-1:0] best_m_q;
  logic [NW-1:0]     best_n_q;
  logic [RCodeW-1:0] best_r_q;

  // Result register.
  logic              out_valid_q;
  logic [MCodeW-1:0] out_m_q;
  logic [NW-1:0]     out_n_q;
  logic [RCodeW-1:0] out_r_q;
  logic [TgtW-1:0]   out_diff_q;

  // Divider connections.
  logic              div_start;
  logic [SrcW-1:0]   div_dividend;
  logic [DivW-1:0]   div_divisor;
  logic              div_done;
  logic [SrcW-1:0]   div_quot;

  // Division of clk by six.
  logic [ProdW-1:0]  q6_prod;
  logic [Q6W-1:0]    q6_calc;
  logic [DivW-1:0]   q6_times6;
  logic [RemW-1:0]   r6_calc;

  // Candidate evaluation.
  logic [FreqW-1:0]  tgt_ext, f2, f4, f8, f_sel;
  logic              fit2, fit4, fit6, fit8;
  logic [RCodeW-1:0] r_sel;
  logic              in_win, better;
  logic [TgtW-1:0]   diff;
  logic [DivW-1:0]   rem_sum;
  logic              rem_wrap;

  // The serial divider gives src / m.
  assign div_start    = cmd_i.div_go_m;
  assign div_dividend = src_q;
  assign div_divisor  = DivW'({1'b0, mcode_q}) + DivW'(1);

  pds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // clk / 6 by reciprocal multiplication; the remainder only needs the low bits,
  // since it lies below six.
  assign q6_prod   = ProdW'(clk_q) * ProdW'(RecipSix);
  assign q6_calc   = q6_prod[RecipShift +: Q6W];
  assign q6_times6 = DivW'(q6_q[RemW-1:0]) * DivBySix;
  assign r6_calc   = RemW'(DivW'(clk_q[RemW-1:0]) - q6_times6);

  // Outputs of the four dividers fall with r, so the first one not above
  // the target is the largest achievable output for this VCO.
  assign tgt_ext = FreqW'(target_i);
  assign f2      = vco_q[FreqW:1];
  assign f4      = vco_q[FreqW+1:2];
  assign f8      = vco_q[FreqW+2:3];
  assign fit2    = f2 <= tgt_ext;
  assign fit4    = f4 <= tgt_ext;
  assign fit6    = f6_q <= tgt_ext;
  assign fit8    = f8 <= tgt_ext;

  always_comb begin
    if (fit2) begin
      f_sel = f2;
      r_sel = RCodeDiv2;
    end else if (fit4) begin
      f_sel = f4;
      r_sel = RCodeDiv4;
    end else if (fit6) begin
      f_sel = f6_q;
      r_sel = RCodeDiv6;
    end else begin
      f_sel = f8;
      r_sel = RCodeDiv8;
    end
  end

  assign in_win = (n_q >= NLow) && (vco_q >= VcoMin) && (vco_q <= VcoMax);
  assign diff   = TgtW'(tgt_ext - f_sel);
  assign better = in_win && fit8 && (diff < best_diff_q);

  // Running remainder of vco / 6, kept below six with one correction.
  assign rem_sum  = DivW'(rem6_q) + DivW'(r6_q);
  assign rem_wrap = rem_sum >= DivBySix;

  // Status toward the controller.
  always_comb begin
    stat_o          = '0;
    stat_o.div_done = div_done | q6_done_q;
    stat_o.clk_ok   = (div_quot >= ClkMin) && (div_quot <= ClkMax);
    stat_o.n_last   = n_q == NHigh;
    stat_o.m_last   = mcode_q == MCodeLast;
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  // The quotient by six is ready in the cycle after it is requested.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q6_done_q <= 1'b0;
    end else begin
      q6_done_q <= cmd_i.div_go_6;
    end
  end

  // Search registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_src) begin
      src_q       <= src_i;
      mcode_q     <= '0;
      best_diff_q <= target_i;
      best_m_q    <= MCodeNone;
      best_n_q    <= NLow;
      best_r_q    <= RCodeDiv2;
    end
    if (cmd_i.next_m) begin
      mcode_q <= mcode_q + MCodeW'(1);
    end
    if (cmd_i.cap_clk) begin
      clk_q <= div_quot[ClkW-1:0];
    end
    if (cmd_i.div_go_6) begin
      q6_q <= q6_calc;
    end
    if (cmd_i.cap_q6) begin
      r6_q <= r6_calc;
    end
    if (cmd_i.init_sweep) begin
      n_q    <= '0;
      vco_q  <= '0;
      f6_q   <= '0;
      rem6_q <= '0;
    end
    if (cmd_i.sweep_step) begin
      if (better) begin
        best_diff_q <= diff;
        best_m_q    <= mcode_q;
        best_n_q    <= n_q;
        best_r_q    <= r_sel;
      end
      n_q   <= n_q + NW'(1);
      vco_q <= vco_q + VcoW'(clk_q);
      if (rem_wrap) begin
        rem6_q <= RemW'(rem_sum - DivBySix);
        f6_q   <= f6_q + FreqW'(q6_q) + FreqW'(1);
      end else begin
        rem6_q <= RemW'(rem_sum);
        f6_q   <= f6_q + FreqW'(q6_q);
      end
    end
  end

  // Result register: holds the answer until the output transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_m_q    <= best_m_q;
      out_n_q    <= best_n_q;
      out_r_q    <= best_r_q;
      out_diff_q <= best_diff_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_m_code_o    = out_m_q;
  assign out_n_mult_o    = out_n_q;
  assign out_r_code_o    = out_r_q;
  assign out_shortfall_o = out_diff_q;

endmodule

`default_nettype wire

@@ test/pll_divider_search_tb.sv @@
// Self-checking testbench for the PLL divider search, with a streaming driver, monitor and predictor.

module pll_divider_search_tb;
  import pds_pkg::*;

  // Search limits of the PLL, in Hz.
  localparam int unsigned CLK_LO_HZ = 4000000;
  localparam int unsigned CLK_HI_HZ = 16000000;
  localparam int unsigned VCO_LO_HZ = 64000000;
  localparam int unsigned VCO_HI_HZ = 344000000;
  localparam int unsigned M_DIV_MAX = 8;
  localparam int unsigned R_DIV_MAX = 8;
  localparam int unsigned TGT_MAX_HZ = 120000000;
  localparam logic [TgtW-1:0] TGT_ALL_ONES = '1;
  localparam logic [SrcW-1:0] SRC_ALL_ONES = '1;

  // Upper bound on the latency of one search, used for the drain at the end.
  localparam int unsigned SEARCH_CYCLES = 1200;
  localparam int unsigned HOLD_CYCLES   = 4000;
  localparam int unsigned BATCH_ITEMS   = 56;
  localparam int unsigned MAX_PRINTED   = 40;

  // One expected search result, with the source that caused it.
  typedef struct packed {
    logic [SrcW-1:0]   src_hz;
    logic [MCodeW-1:0] m_code;
    logic [NW-1:0]     n_mult;
    logic [RCodeW-1:0] r_code;
    logic [TgtW-1:0]   shortfall;
  } pll_pick_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [26:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  logic [SrcW-1:0] pending_src_q[$];
  pll_pick_t       expected_pick_q[$];
  logic [TgtW-1:0] target_hz = TargetReset;

  int unsigned src_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned mismatches   = 0;
  logic        hold_go      = 1'b0;
  logic        rx_hold      = 1'b0;

  pll_divider_search u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Exhaustive search over m, n and r; a later candidate only wins with a strictly
  // smaller shortfall, so ties keep the first one found.
  function automatic pll_pick_t pick_pll_divisors(input logic [SrcW-1:0] src,
                                                  input logic [TgtW-1:0] target);
    pll_pick_t   best;
    int unsigned clk_hz;
    int unsigned vco_hz;
    int unsigned out_hz;
    best.src_hz    = src;
    best.m_code    = MCodeNone;
    best.n_mult    = NLow;
    best.r_code    = RCodeDiv2;
    best.shortfall = target;
    for (int unsigned m = 1; m <= M_DIV_MAX; m++) begin
      clk_hz = int'(src) / m;
      if (clk_hz < CLK_LO_HZ || clk_hz > CLK_HI_HZ) continue;
      for (int unsigned n = NLow; n <= NHigh; n++) begin
        vco_hz = clk_hz * n;
        if (vco_hz < VCO_LO_HZ || vco_hz > VCO_HI_HZ) continue;
        for (int unsigned r = 2; r <= R_DIV_MAX; r += 2) begin
          out_hz = vco_hz / r;
          if (out_hz <= target && (target - out_hz) < best.shortfall) begin
            best.shortfall = TgtW'(target - out_hz);
            best.m_code    = MCodeW'(m - 1);
            best.n_mult    = NW'(n);
            best.r_code    = RCodeW'(r / 2 - 1);
          end
        end
      end
    end
    return best;
  endfunction

  // Mostly common crystal frequencies and the usable range, with some edges and noise.
  function automatic logic [SrcW-1:0] random_src();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      case ($urandom_range(11))
        0:       return SrcW'(4000000);
        1:       return SrcW'(8000000);
        2:       return SrcW'(12000000);
        3:       return SrcW'(16000000);
        4:       return SrcW'(19200000);
        5:       return SrcW'(24000000);
        6:       return SrcW'(25000000);
        7:       return SrcW'(26000000);
        8:       return SrcW'(32000000);
        9:       return SrcW'(38400000);
        10:      return SrcW'(48000000);
        default: return SrcW'(64000000);
      endcase
    end else if (pick < 82) begin
      return SrcW'($urandom_range(64000000, 1000000));
    end else if (pick < 90) begin
      return SrcW'($urandom_range(4000100, 3999900));
    end else begin
      return SrcW'($urandom);
    end
  endfunction

  // Targets at the extremes, below every reachable output, in range, and full width.
  function automatic logic [TgtW-1:0] random_target();
    case ($urandom_range(9))
      0:       return '0;
      1:       return TGT_ALL_ONES;
      2:       return TgtW'(TGT_MAX_HZ);
      3:       return TgtW'($urandom_range(7999999));
      4, 5:    return TgtW'($urandom);
      default: return TgtW'($urandom_range(TGT_MAX_HZ, 8000000));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want, input int unsigned src);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] mismatch in %s: got %0d, expected %0d (src %0d Hz)",
               $realtime, what, got, want, src);
    mismatches++;
  endtask

  // Write the target register and mirror it in the predictor.
  task automatic write_target(input logic [TgtW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    target_hz = value;
  endtask

  // Block until every queued item has been sent and every result has arrived.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_src_q.size() != 0 || s_axis_tvalid || expected_pick_q.size() != 0);
  endtask

  // Input driver: predicts each accepted transaction and offers the next pending item.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_pick_q.push_back(pick_pll_divisors(s_axis_tdata[SrcW-1:0], target_hz));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_src_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, pending_src_q.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    pll_pick_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pick_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[38:12], 0, 0);
        end else begin
          want = expected_pick_q.pop_front();
          if (m_axis_tdata[2:0] !== want.m_code)
            report_mismatch("m_code", m_axis_tdata[2:0], want.m_code, want.src_hz);
          if (m_axis_tdata[9:3] !== want.n_mult)
            report_mismatch("n_mult", m_axis_tdata[9:3], want.n_mult, want.src_hz);
          if (m_axis_tdata[11:10] !== want.r_code)
            report_mismatch("r_code", m_axis_tdata[11:10], want.r_code, want.src_hz);
          if (m_axis_tdata[38:12] !== want.shortfall)
            report_mismatch("freq_shortfall", m_axis_tdata[38:12], want.shortfall,
                            want.src_hz);
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Long receiver hold-off so that the block fills up and stalls its input.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Stimulus sequencing.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset target: too slow, too fast, band edges, full width and common crystals.
    pending_src_q = '{SrcW'(0), SrcW'(1), SrcW'(3999999), SrcW'(4000000), SrcW'(7999999),
                      SrcW'(8000000), SrcW'(12000000), SrcW'(16000000), SrcW'(16000001),
                      SrcW'(19200000), SrcW'(25000000), SrcW'(32000000), SrcW'(48000000),
                      SrcW'(64000000), SrcW'(64000001), SRC_ALL_ONES};
    wait_drained();

    // A zero target leaves nothing that can win.
    write_target('0);
    pending_src_q = '{SrcW'(8000000), SrcW'(25000000)};
    wait_drained();

    // The widest target, then one below every reachable output, then the range top.
    write_target(TGT_ALL_ONES);
    pending_src_q = '{SrcW'(16000000), SRC_ALL_ONES};
    wait_drained();
    write_target(TgtW'(7999999));
    pending_src_q.push_back(SrcW'(16000000));
    wait_drained();
    write_target(TgtW'(TGT_MAX_HZ));
    pending_src_q.push_back(SrcW'(48000000));
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalls, both, then a long hold-off.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin src_idle_pct = 72; rx_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  rx_stall_pct = 72; end
        3:       begin src_idle_pct = 36; rx_stall_pct = 36; end
        default: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
      for (int batch = 0; batch < 2; batch++) begin
        write_target(random_target());
        if (phase == 4 && batch == 0) hold_go = 1'b1;
        repeat (BATCH_ITEMS) pending_src_q.push_back(random_src());
        wait_drained();
      end
    end

    // Let any stray result show up before the verdict.
    repeat (SEARCH_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_pick_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #80000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/pds_pkg.sv
design/pds_div.sv
design/pds_ctrl.sv
design/pds_datapath.sv
design/pll_divider_search.sv
test/pll_divider_search_tb.sv
